@@ rtl/dsv_pkg.sv @@
// Shared packed type, constants and month-length helper function of the date string validator.
package dsv_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned POS_W   = 4;
    localparam int unsigned DAY_W   = 7;
    localparam int unsigned MONTH_W = 7;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MLEN_W  = 5;

    localparam logic [POS_W-1:0]  DATE_LEN = POS_W'(10);
    localparam logic [POS_W-1:0]  POS_SAT  = POS_W'(11);

    // Character positions inside dd/mm/yyyy.
    localparam logic [POS_W-1:0]  POS_SLASH_A  = POS_W'(2);
    localparam logic [POS_W-1:0]  POS_SLASH_B  = POS_W'(5);
    localparam logic [POS_W-1:0]  POS_YEAR_LOW = POS_W'(8);

    localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    localparam logic [YEAR_W-1:0] MIN_YEAR       = YEAR_W'(1900);
    localparam logic [YEAR_W-1:0] MAX_YEAR_RESET = YEAR_W'(2011);

    // Finished string, handed from the accumulator to the judge stage.
    typedef struct packed {
        logic                 len_ok;
        logic                 fmt_err;
        logic [DAY_W-1:0]     day;
        logic [MONTH_W-1:0]   month;
        logic [YEAR_W-1:0]    year;
        logic                 leap;
    } snap_t;

    // Days in a month; months outside 1..12 are rejected elsewhere.
    function automatic logic [MLEN_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
        logic [MLEN_W-1:0] len;
        len = MLEN_W'(31);
        case (month) inside
            MONTH_W'(4), MONTH_W'(6), MONTH_W'(9), MONTH_W'(11):
                len = MLEN_W'(30);
            MONTH_W'(2):
                len = leap ? MLEN_W'(29) : MLEN_W'(28);
            default:
                len = MLEN_W'(31);
        endcase
        return len;
    endfunction

endpackage

@@ rtl/dsv_accum.sv @@
// Input register and per-character accumulation of day, month, year and format.
module dsv_accum (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [dsv_pkg::CHAR_W-1:0]   s_tdata,   // [7:0] char_code
    input  logic                         s_tlast,   // last_char
    input  logic                         snap_free,
    output logic                         snap_load,
    output dsv_pkg::snap_t               snap
);

    logic                          in_valid_reg;
    logic [dsv_pkg::CHAR_W-1:0]    in_char_reg;
    logic                          in_last_reg;

    logic [dsv_pkg::POS_W-1:0]     pos_reg,   pos_next;
    logic [dsv_pkg::DAY_W-1:0]     day_reg,   day_next;
    logic [dsv_pkg::MONTH_W-1:0]   month_reg, month_next;
    logic [dsv_pkg::YEAR_W-1:0]    year_reg,  year_next;
    logic                          ferr_reg,  ferr_next;
    logic [1:0]                    hi4_reg,   hi4_next;
    logic [1:0]                    lo4_reg,   lo4_next;
    logic                          loz_reg,   loz_next;

    logic                          adv;
    logic                          is_digit;
    logic [3:0]                    digit;

    assign adv       = in_valid_reg && (!in_last_reg || snap_free);
    assign s_tready  = !in_valid_reg || adv;
    assign snap_load = adv && in_last_reg;

    assign is_digit = (in_char_reg >= dsv_pkg::CHAR_ZERO) && (in_char_reg <= dsv_pkg::CHAR_NINE);
    assign digit    = in_char_reg[3:0];

    always_comb
    begin
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        ferr_next  = ferr_reg;
        hi4_next   = hi4_reg;
        lo4_next   = lo4_reg;
        loz_next   = loz_reg;
        pos_next   = (pos_reg < dsv_pkg::POS_SAT) ? pos_reg + 1'b1 : pos_reg;

        if (pos_reg < dsv_pkg::DATE_LEN)
        begin
            if (pos_reg == dsv_pkg::POS_SLASH_A || pos_reg == dsv_pkg::POS_SLASH_B)
            begin
                if (in_char_reg != dsv_pkg::CHAR_SLASH)
                    ferr_next = 1'b1;
            end
            else if (!is_digit)
            begin
                ferr_next = 1'b1;
            end
            else if (pos_reg < dsv_pkg::POS_SLASH_A)
            begin
                day_next = dsv_pkg::DAY_W'({day_reg, 3'b000})
                         + dsv_pkg::DAY_W'({day_reg, 1'b0})
                         + dsv_pkg::DAY_W'(digit);
            end
            else if (pos_reg < dsv_pkg::POS_SLASH_B)
            begin
                month_next = dsv_pkg::MONTH_W'({month_reg, 3'b000})
                           + dsv_pkg::MONTH_W'({month_reg, 1'b0})
                           + dsv_pkg::MONTH_W'(digit);
            end
            else
            begin
                year_next = dsv_pkg::YEAR_W'({year_reg, 3'b000})
                          + dsv_pkg::YEAR_W'({year_reg, 1'b0})
                          + dsv_pkg::YEAR_W'(digit);
                // (10a + b) mod 4 equals (2a + b) mod 4, so each pair of year
                // digits is reduced on the fly for the leap rule.
                if (pos_reg < dsv_pkg::POS_YEAR_LOW)
                begin
                    hi4_next = {hi4_reg[0], 1'b0} + digit[1:0];
                end
                else
                begin
                    lo4_next = {lo4_reg[0], 1'b0} + digit[1:0];
                    loz_next = loz_reg && (digit == 4'd0);
                end
            end
        end
    end

    always_comb
    begin
        snap.len_ok  = (pos_next == dsv_pkg::DATE_LEN);
        snap.fmt_err = ferr_next;
        snap.day     = day_next;
        snap.month   = month_next;
        snap.year    = year_next;
        snap.leap    = loz_next ? (hi4_next == 2'd0) : (lo4_next == 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            day_reg   <= '0;
            month_reg <= '0;
            year_reg  <= '0;
            ferr_reg  <= 1'b0;
            hi4_reg   <= 2'd0;
            lo4_reg   <= 2'd0;
            loz_reg   <= 1'b1;
        end
        else if (adv)
        begin
            if (in_last_reg)
            begin
                pos_reg   <= '0;
                day_reg   <= '0;
                month_reg <= '0;
                year_reg  <= '0;
                ferr_reg  <= 1'b0;
                hi4_reg   <= 2'd0;
                lo4_reg   <= 2'd0;
                loz_reg   <= 1'b1;
            end
            else
            begin
                pos_reg   <= pos_next;
                day_reg   <= day_next;
                month_reg <= month_next;
                year_reg  <= year_next;
                ferr_reg  <= ferr_next;
                hi4_reg   <= hi4_next;
                lo4_reg   <= lo4_next;
                loz_reg   <= loz_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= dsv_pkg::POS_SAT)
        else $error("character position beyond saturation");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && in_last_reg) |=> (pos_reg == '0 && !ferr_reg && year_reg == '0))
        else $error("state not cleared after last character");

    a_last_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        snap_load |-> snap_free)
        else $error("finished string dropped while judge stage busy");
`endif

endmodule

@@ rtl/dsv_judge.sv @@
// Snapshot register, date range checks and the registered result.
module dsv_judge (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         snap_load,
    input  dsv_pkg::snap_t               snap,
    output logic                         snap_free,
    input  logic [dsv_pkg::YEAR_W-1:0]   max_year,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [7:0]                   m_tdata    // [0] date_valid, [7:1] zero
);

    logic              snap_valid_reg;
    dsv_pkg::snap_t    snap_reg;
    logic              out_valid_reg;
    logic              out_bit_reg;
    logic              out_free;
    logic              move;
    logic              verdict;

    assign out_free  = !out_valid_reg || m_tready;
    assign snap_free = !snap_valid_reg || out_free;
    assign move      = snap_valid_reg && out_free;

    always_comb
    begin
        verdict = snap_reg.len_ok && !snap_reg.fmt_err
               && (snap_reg.day >= dsv_pkg::DAY_W'(1))
               && (snap_reg.day <= dsv_pkg::DAY_W'(31))
               && (snap_reg.month >= dsv_pkg::MONTH_W'(1))
               && (snap_reg.month <= dsv_pkg::MONTH_W'(12))
               && (snap_reg.year >= dsv_pkg::MIN_YEAR)
               && (snap_reg.year <= max_year)
               && (snap_reg.day <= dsv_pkg::DAY_W'(dsv_pkg::month_len(snap_reg.month,
                                                                      snap_reg.leap)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (snap_free)
                snap_valid_reg <= snap_load;
            if (out_free)
                out_valid_reg <= snap_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_load && snap_free)
            snap_reg <= snap;
        if (move)
            out_bit_reg <= verdict;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0000000, out_bit_reg};

`ifndef SYNTHESIS
    a_result_from_snapshot: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(snap_valid_reg))
        else $error("result appeared without a finished string");

    a_valid_needs_length: assert property (@(posedge clk) disable iff (!rst_n)
        (move && verdict) |-> (snap_reg.len_ok && !snap_reg.fmt_err))
        else $error("accepted a string of wrong length or format");

    a_one_result_per_string: assert property (@(posedge clk) disable iff (!rst_n)
        (move && !snap_load) |=> !snap_valid_reg)
        else $error("snapshot not released after its result was taken");
`endif

endmodule

@@ rtl/date_string_validator.sv @@
// Top level of the dd/mm/yyyy date string validator.
//
//  Channel   Direction  Handshake            Payload
//  s_*       in         s_tvalid/s_tready    s_tdata = char_code, s_tlast = last_char
//  m_*       out        m_tvalid/m_tready    m_tdata[0] = date_valid
//  cfg_*     in         cfg_valid/cfg_ready  cfg_data = max_year
//
// One character request is taken every cycle while the result side keeps up.
// A character passes the input register, the accumulator logic, the snapshot
// register and the result register, and the verdict for a string appears once
// its last character has passed them all. Only the last character of a
// string waits for room in the snapshot stage; other characters keep flowing
// while a verdict sits unclaimed on the result side. Reset clears the
// per-string state and loads max_year with 2011. The configuration channel is
// always ready and is meant to be written only while no string is in flight.
module date_string_validator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,    // [7:0] char_code
    input  logic                         s_tlast,    // last_char
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [7:0]                   m_tdata,    // [0] date_valid, [7:1] zero
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [dsv_pkg::YEAR_W-1:0]   cfg_data    // max_year
);

    // Latest year that is still accepted.
    logic [dsv_pkg::YEAR_W-1:0] max_year_reg;

    logic              snap_load;
    logic              snap_free;
    dsv_pkg::snap_t    snap;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_year_reg <= dsv_pkg::MAX_YEAR_RESET;
        else if (cfg_valid && cfg_ready)
            max_year_reg <= cfg_data;
    end

    // Character-by-character parsing of the string.
    dsv_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .snap_free (snap_free),
        .snap_load (snap_load),
        .snap      (snap)
    );

    // Range and calendar checks on the finished string.
    dsv_judge u_judge (
        .clk       (clk),
        .rst_n     (rst_n),
        .snap_load (snap_load),
        .snap      (snap),
        .snap_free (snap_free),
        .max_year  (max_year_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the dd/mm/yyyy date string validator.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Number of characters sent by the random part.
    localparam int RANDOM_CHARS = 900;
    // Cycles allowed after the last verdict before the block counts as idle.
    localparam int SETTLE_CYCLES = 8;
    // Longest string that the random part builds.
    localparam int TEXT_MAX = 16;

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [7:0]                    s_tdata;     // [7:0] char_code
    logic                          s_tlast;     // last_char
    logic                          m_tvalid;
    logic                          m_tready;
    logic [7:0]                    m_tdata;     // [0] date_valid, [7:1] zero
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [dsv_pkg::YEAR_W-1:0]    cfg_data;    // max_year

    date_string_validator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // The testbench's own copy of the block's state. It is advanced on every
    // accepted character request and cleared after every marked character.
    logic [dsv_pkg::YEAR_W-1:0]    max_year_cfg;
    logic [dsv_pkg::POS_W-1:0]     str_pos;
    logic [dsv_pkg::DAY_W-1:0]     day_acc;
    logic [dsv_pkg::MONTH_W-1:0]   mon_acc;
    logic [dsv_pkg::YEAR_W-1:0]    yr_acc;
    logic                          str_bad;

    // Verdicts that have been predicted but not yet seen on the result side.
    logic                 expected_verdicts[$];
    int                   mismatch_count;

    // Sender burst bookkeeping and the string being sent.
    int                   burst_left;
    int                   sent_chars;
    logic [7:0]           text_buf [0:TEXT_MAX-1];
    int                   text_len;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: a correct run ends long before this.
    initial
    begin
        #(5_000_000);
        $display("Mismatches found");
        $finish;
    end

    // Days in a month under the Gregorian leap rule. Months outside 1..12
    // are turned away before this matters, so they get 31.
    function automatic int days_in_month(input int month, input int year);
        bit leap;
        leap = ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
        if (month == 4 || month == 6 || month == 9 || month == 11)
            return 30;
        if (month == 2)
            return leap ? 29 : 28;
        return 31;
    endfunction

    // Verdict for the string that has just ended, from the tracked state.
    function automatic logic date_verdict();
        if (str_pos != dsv_pkg::DATE_LEN || str_bad)
            return 1'b0;
        if (day_acc < 1 || day_acc > 31)
            return 1'b0;
        if (mon_acc < 1 || mon_acc > 12)
            return 1'b0;
        if (yr_acc < dsv_pkg::MIN_YEAR || yr_acc > max_year_cfg)
            return 1'b0;
        if (int'(day_acc) > days_in_month(int'(mon_acc), int'(yr_acc)))
            return 1'b0;
        return 1'b1;
    endfunction

    task automatic clear_string_state();
        str_pos = '0;
        day_acc = '0;
        mon_acc = '0;
        yr_acc  = '0;
        str_bad = 1'b0;
    endtask

    // Advances the tracked state by one accepted character. Only positions
    // 0..9 are examined; the position count stops at its saturation value.
    task automatic track_char(input logic [7:0] code, input logic last);
        int digit;
        if (str_pos < dsv_pkg::DATE_LEN)
        begin
            if (str_pos == dsv_pkg::POS_SLASH_A || str_pos == dsv_pkg::POS_SLASH_B)
            begin
                if (code != dsv_pkg::CHAR_SLASH)
                    str_bad = 1'b1;
            end
            else if (code < dsv_pkg::CHAR_ZERO || code > dsv_pkg::CHAR_NINE)
                str_bad = 1'b1;
            else
            begin
                digit = int'(code) - int'(dsv_pkg::CHAR_ZERO);
                if (str_pos < dsv_pkg::POS_SLASH_A)
                    day_acc = dsv_pkg::DAY_W'(int'(day_acc) * 10 + digit);
                else if (str_pos < dsv_pkg::POS_SLASH_B)
                    mon_acc = dsv_pkg::MONTH_W'(int'(mon_acc) * 10 + digit);
                else
                    yr_acc = dsv_pkg::YEAR_W'(int'(yr_acc) * 10 + digit);
            end
        end
        if (str_pos < dsv_pkg::POS_SAT)
            str_pos = str_pos + 1'b1;
        if (last)
        begin
            expected_verdicts.push_back(date_verdict());
            clear_string_state();
        end
    endtask

    // Sends one character request. The sender runs in bursts: when a burst is
    // used up, tvalid drops for a random gap (sometimes none) before the next
    // one starts. Called and left at a falling edge, so tvalid gets one
    // assignment per time step.
    task automatic send_char(input logic [7:0] code, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        track_char(code, last);
        sent_chars++;
        burst_left--;
        @(negedge clk);
    endtask

    task automatic send_text();
        for (int i = 0; i < text_len; i++)
            send_char(text_buf[i], i == text_len - 1);
    endtask

    task automatic put_text(input string s);
        text_len = s.len();
        for (int i = 0; i < text_len; i++)
            text_buf[i] = s[i];
    endtask

    // Writes day, month and year as dd/mm/yyyy into the string buffer.
    task automatic put_date(input int day, input int month, input int year);
        text_buf[0] = dsv_pkg::CHAR_ZERO + 8'(day / 10);
        text_buf[1] = dsv_pkg::CHAR_ZERO + 8'(day % 10);
        text_buf[2] = dsv_pkg::CHAR_SLASH;
        text_buf[3] = dsv_pkg::CHAR_ZERO + 8'(month / 10);
        text_buf[4] = dsv_pkg::CHAR_ZERO + 8'(month % 10);
        text_buf[5] = dsv_pkg::CHAR_SLASH;
        text_buf[6] = dsv_pkg::CHAR_ZERO + 8'(year / 1000);
        text_buf[7] = dsv_pkg::CHAR_ZERO + 8'((year / 100) % 10);
        text_buf[8] = dsv_pkg::CHAR_ZERO + 8'((year / 10) % 10);
        text_buf[9] = dsv_pkg::CHAR_ZERO + 8'(year % 10);
        text_len = 10;
    endtask

    task automatic send_date(input int day, input int month, input int year);
        put_date(day, month, year);
        send_text();
    endtask

    // Holds the sender off until every predicted verdict has come back, then
    // lets the pipeline settle. Entered and left at a falling edge.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_verdicts.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes max_year through the configuration channel once the block is idle.
    task automatic write_max_year(input logic [dsv_pkg::YEAR_W-1:0] year);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= year;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        max_year_cfg = year;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Builds one random string. Most are well-formed dates with random
    // content near the interesting bounds; the rest are broken by a wrong
    // character, cut short, run long, or are plain noise.
    task automatic make_random_text();
        int top, day, month, year, pick, at;
        top = (max_year_cfg >= dsv_pkg::MIN_YEAR) ? int'(max_year_cfg)
                                                  : int'(dsv_pkg::MIN_YEAR);
        if (top > 9999)
            top = 9999;

        month = ($urandom_range(0, 99) < 88) ? $urandom_range(1, 12) : $urandom_range(0, 99);

        pick = $urandom_range(0, 99);
        if (pick < 45)
            year = $urandom_range(int'(dsv_pkg::MIN_YEAR), top);
        else if (pick < 55)
            year = $urandom_range(int'(dsv_pkg::MIN_YEAR), top) & ~3;
        else if (pick < 62)
            year = $urandom_range(19, 99) * 100;
        else if (pick < 80)
        begin
            case ($urandom_range(0, 3))
                0: year = int'(dsv_pkg::MIN_YEAR);
                1: year = int'(dsv_pkg::MIN_YEAR) - 1;
                2: year = top;
                default: year = (top < 9999) ? top + 1 : top;
            endcase
        end
        else
            year = $urandom_range(0, 9999);

        pick = $urandom_range(0, 99);
        if (pick < 60)
            day = $urandom_range(1, days_in_month(month, year));
        else if (pick < 80)
            day = days_in_month(month, year) + $urandom_range(0, 1);
        else
            day = $urandom_range(0, 99);

        put_date(day, month, year);

        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            at = $urandom_range(0, 9);
            text_buf[at] = 8'($urandom_range(0, 255));
        end
        else if (pick < 18)
            text_len = $urandom_range(1, 9);
        else if (pick < 24)
        begin
            text_len = $urandom_range(11, TEXT_MAX);
            for (int i = 10; i < text_len; i++)
                text_buf[i] = 8'($urandom_range(0, 255));
        end
        else if (pick < 28)
        begin
            text_len = $urandom_range(1, TEXT_MAX);
            for (int i = 0; i < text_len; i++)
                text_buf[i] = 8'($urandom_range(0, 255));
        end
    endtask

    // Day and month limits, the leap rule, and the year bound at its reset value.
    task automatic test_calendar_limits();
        send_date(1, 1, 1900);
        send_date(31, 12, 2011);
        send_date(29, 2, 2000);    // divisible by 400, leap
        send_date(29, 2, 1900);    // century, not leap
        send_date(29, 2, 2008);
        send_date(31, 4, 2000);
        send_date(0, 5, 2000);
        send_date(32, 1, 2000);
        send_date(15, 0, 2000);
        send_date(15, 13, 2000);
        send_date(1, 1, 2012);     // one past the reset bound
        send_date(1, 1, 1899);
        send_date(99, 99, 9999);
    endtask

    // Wrong characters, a zero byte, and strings of the wrong length.
    task automatic test_format_errors();
        put_text("01-01-2000");
        send_text();
        put_date(1, 1, 2000);
        text_buf[4] = 8'h00;       // a zero byte does not end the string
        send_text();
        put_date(1, 1, 2000);
        text_buf[0] = 8'hFF;
        send_text();
        put_text("1/1/2000");
        send_text();
        put_text("7");
        send_text();
        // A good date followed by more characters is still too long.
        put_date(1, 1, 2000);
        text_buf[10] = 8'h00;
        text_buf[11] = dsv_pkg::CHAR_SLASH;
        text_len = 12;
        send_text();
    endtask

    // The year bound at its extremes, including values below the first year.
    task automatic test_year_bound();
        write_max_year(dsv_pkg::YEAR_W'(1900));
        send_date(1, 1, 1900);
        send_date(1, 1, 1901);
        write_max_year(dsv_pkg::YEAR_W'(9999));
        send_date(31, 12, 9999);
        send_date(29, 2, 9996);
        write_max_year(dsv_pkg::YEAR_W'(16383));
        send_date(1, 1, 9999);
        write_max_year(dsv_pkg::YEAR_W'(0));
        send_date(1, 1, 1900);
        write_max_year(dsv_pkg::YEAR_W'(1899));
        send_date(1, 1, 1900);
    endtask

    // Random strings in phases, each phase under its own year bound. Now and
    // then the sender also pauses until every verdict is back.
    task automatic test_random_strings();
        int stop_at, phase_left;
        stop_at = sent_chars + RANDOM_CHARS;
        phase_left = 0;
        while (sent_chars < stop_at)
        begin
            if (phase_left == 0)
            begin
                case ($urandom_range(0, 6))
                    0: write_max_year(dsv_pkg::MAX_YEAR_RESET);
                    1: write_max_year(dsv_pkg::YEAR_W'(1900));
                    2: write_max_year(dsv_pkg::YEAR_W'(9999));
                    3: write_max_year(dsv_pkg::YEAR_W'(16383));
                    4: write_max_year(dsv_pkg::YEAR_W'($urandom_range(0, 16383)));
                    default: write_max_year(dsv_pkg::YEAR_W'($urandom_range(1900, 9999)));
                endcase
                phase_left = $urandom_range(8, 40);
            end
            make_random_text();
            send_text();
            phase_left--;
            if ($urandom_range(0, 19) == 0)
                wait_drained();
        end
    endtask

    // The result side stalls on a pattern of its own: stretches of steady
    // acceptance, coin flips, sparse acceptance and long stalls.
    initial
    begin : result_stall_pattern
        int mode;
        int span;
        m_tready = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 96);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 19) == 0);
                endcase
            end
        end
    end

    // Each accepted result request is compared with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        logic [7:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got m_tdata=%h",
                         $time, m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = {7'b0, expected_verdicts.pop_front()};
                if (m_tdata !== want)
                begin
                    $display("%0t: date_valid mismatch, expected %h, got %h",
                             $time, want, m_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        mismatch_count = 0;
        burst_left = 0;
        sent_chars = 0;
        text_len   = 0;
        max_year_cfg = dsv_pkg::MAX_YEAR_RESET;
        clear_string_state();

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        test_calendar_limits();
        test_format_errors();
        test_year_bound();
        test_random_strings();

        // Let every outstanding verdict come back before judging the run.
        wait_drained();
        if (expected_verdicts.size() != 0)
        begin
            $display("%0t: %0d verdicts never arrived", $time, expected_verdicts.size());
            mismatch_count++;
        end

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ date_string_validator.f @@
rtl/dsv_pkg.sv
rtl/dsv_accum.sv
rtl/dsv_judge.sv
rtl/date_string_validator.sv
tb/sv/tb.sv
